@@ design/odh_pkg.sv @@
// Shared types, constants and the arctangent step-angle function for the
// odometry heading tracker. No dependencies.
package odh_pkg;

    // Default sizing of the CORDIC
    localparam int CORDIC_STEPS_DEF    = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 12;

    // Field widths
    localparam int TICK_W  = 16;
    localparam int TPC_W   = 12;
    localparam int WB_W    = 8;
    localparam int HEAD_W  = 9;
    localparam int CFG_W   = 12;
    localparam int INDEX_W = 2;

    // Vector datapath: x0 < 2^40 and |y0| < 2^41, with CORDIC gain headroom
    localparam int PRESCALE_BITS = 20;
    localparam int XY_W          = 44;

    // Register indexes
    localparam logic [INDEX_W-1:0] REG_TICKS_PER_CM = 2'd0;
    localparam logic [INDEX_W-1:0] REG_WHEEL_BASE   = 2'd1;

    // Register reset values
    localparam logic [TPC_W-1:0] TICKS_PER_CM_RST = 12'd152;
    localparam logic [WB_W-1:0]  WHEEL_BASE_RST   = 8'd30;

    // Heading wrap limits in whole degrees
    localparam int HEAD_LIMIT = 180;
    localparam int FULL_TURN  = 360;

    // 180/pi with 24 fractional bits
    localparam logic [63:0] RAD2DEG_Q24 = 64'd961263669;

    // Control from the sequencer to the CORDIC unit
    typedef struct packed {
        logic start;
        logic skip;
    } odh_cordic_ctl_t;

    // 2^e, or zero once the series term has dropped below one LSB
    function automatic logic [63:0] pow2_or_zero(input int e);
        logic [63:0] r;
        r = (e >= 0) ? (64'd1 << e) : 64'd0;
        return r;
    endfunction

    // atan(2^-i) in degrees with frac fractional bits; elaboration use only.
    // Series in radians, each term truncated to 32 fractional bits.
    function automatic logic [63:0] step_angle(input int i, input int frac);
        logic [63:0] rad;
        logic [63:0] deg;
        rad = pow2_or_zero(32 - i)
            - pow2_or_zero(32 - 3 * i) / 3
            + pow2_or_zero(32 - 5 * i) / 5
            - pow2_or_zero(32 - 7 * i) / 7
            + pow2_or_zero(32 - 9 * i) / 9
            - pow2_or_zero(32 - 11 * i) / 11
            + pow2_or_zero(32 - 13 * i) / 13
            - pow2_or_zero(32 - 15 * i) / 15
            + pow2_or_zero(32 - 17 * i) / 17
            - pow2_or_zero(32 - 19 * i) / 19
            + pow2_or_zero(32 - 21 * i) / 21
            - pow2_or_zero(32 - 23 * i) / 23
            + pow2_or_zero(32 - 25 * i) / 25
            - pow2_or_zero(32 - 27 * i) / 27
            + pow2_or_zero(32 - 29 * i) / 29
            - pow2_or_zero(32 - 31 * i) / 31;
        deg = rad * RAD2DEG_Q24 + (64'd1 << (55 - frac));
        if (i == 0) begin
            deg = 64'd45 << frac;
        end else begin
            deg = deg >> (56 - frac);
        end
        return deg;
    endfunction

endpackage

@@ design/odh_cordic.sv @@
// Iterative vectoring CORDIC: one shift/add step per cycle on x, y and the
// angle accumulator. Depends on odh_pkg.
module odh_cordic #(
    parameter int CORDIC_STEPS    = odh_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = odh_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  odh_pkg::odh_cordic_ctl_t              ctl,
    input  logic signed [odh_pkg::TICK_W-1:0]     left_ticks,
    input  logic signed [odh_pkg::TICK_W-1:0]     right_ticks,
    input  logic        [odh_pkg::TPC_W-1:0]      ticks_per_cm_q4,
    input  logic        [odh_pkg::WB_W-1:0]       wheel_base_cm,
    output logic                                  done,
    output logic signed [ANGLE_FRAC_BITS+7:0]     angle
);

    localparam int ANGLE_W = ANGLE_FRAC_BITS + 8;
    localparam int STEP_W  = $clog2(CORDIC_STEPS);
    localparam int XY_W    = odh_pkg::XY_W;
    localparam int PROD_W  = odh_pkg::TPC_W + odh_pkg::WB_W;

    logic signed [XY_W-1:0]    x_reg, x_next;
    logic signed [XY_W-1:0]    y_reg, y_next;
    logic signed [ANGLE_W-1:0] z_reg, z_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      run_reg, run_next;
    logic                      done_reg, done_next;

    logic [PROD_W-1:0]         base_prod;
    logic signed [odh_pkg::TICK_W:0] diff;
    logic signed [XY_W-1:0]    x_start, y_start;
    logic signed [XY_W-1:0]    xs, ys;
    logic [ANGLE_W-1:0]        angle_tbl [CORDIC_STEPS];
    logic signed [ANGLE_W-1:0] step_ang;
    logic                      last_step;

    // Step-angle table, constant per step
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_angle
        assign angle_tbl[g] = ANGLE_W'(odh_pkg::step_angle(g, ANGLE_FRAC_BITS));
    end

    // Starting vector: x = tpc*wb*2^20, y = 16*(left-right)*2^20
    assign base_prod = PROD_W'(ticks_per_cm_q4) * PROD_W'(wheel_base_cm);
    assign diff      = (odh_pkg::TICK_W + 1)'(left_ticks)
                     - (odh_pkg::TICK_W + 1)'(right_ticks);
    assign x_start   = $signed(XY_W'(base_prod) << odh_pkg::PRESCALE_BITS);
    assign y_start   = XY_W'(diff) <<< (odh_pkg::PRESCALE_BITS + 4);

    // Shared step unit
    assign xs        = x_reg >>> step_reg;
    assign ys        = y_reg >>> step_reg;
    assign step_ang  = $signed(angle_tbl[step_reg]);
    assign last_step = (step_reg == STEP_W'(CORDIC_STEPS - 1));

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (ctl.start) begin
            x_next    = x_start;
            y_next    = y_start;
            z_next    = '0;
            step_next = '0;
            run_next  = !ctl.skip;
            done_next = ctl.skip;
        end else if (run_reg) begin
            // rotate toward the x axis
            if (!y_reg[XY_W-1]) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + step_ang;
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - step_ang;
            end
            step_next = step_reg + STEP_W'(1);
            if (last_step) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        step_reg <= step_next;
    end

    assign done  = done_reg;
    assign angle = z_reg;

endmodule

@@ design/odometry_heading_tracker.sv @@
// Differential-drive heading tracker: configuration registers, item sequencer,
// heading accumulator and wrap. Depends on odh_pkg and odh_cordic.
//
// Usage:
//   Input channel s_*: one item carries the left and right encoder tick counts
//   of one interval. Result channel m_*: one item per input item, the updated
//   heading in whole degrees, -180..180.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0 = ticks per cm, Q4; 1 = wheel base in cm); other indexes are ignored.
//   Flow: an accepted item starts the CORDIC, which is bypassed when both
//   counts are equal; its result is committed from ST_FIN. The shared CORDIC
//   step unit does one iteration per cycle; s_ready is high only while the
//   unit is idle and stays low until the result is committed, so a new item
//   is not taken until the previous one has been committed.
//   The heading register doubles as the result register: a new item may be
//   accepted while a result waits, but its heading is committed only once the
//   receiver has taken the previous one, so a stall on m_ready holds the block.
//   Reset: heading clears to 0, registers return to 152 and 30, no result
//   is pending.
module odometry_heading_tracker #(
    parameter int CORDIC_STEPS    = odh_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = odh_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [odh_pkg::INDEX_W-1:0]         cfg_index,
    input  logic [odh_pkg::CFG_W-1:0]           cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [odh_pkg::TICK_W-1:0]   s_left_ticks,
    input  logic signed [odh_pkg::TICK_W-1:0]   s_right_ticks,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [odh_pkg::HEAD_W-1:0]   m_heading_deg
);

    localparam int ANGLE_W = ANGLE_FRAC_BITS + 8;
    localparam int SUM_W   = ANGLE_FRAC_BITS + 10;
    localparam int HQ_W    = odh_pkg::HEAD_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t                            state_reg, state_next;
    logic [odh_pkg::TPC_W-1:0]         tpc_reg, tpc_next;
    logic [odh_pkg::WB_W-1:0]          wb_reg, wb_next;
    logic signed [odh_pkg::HEAD_W-1:0] heading_reg, heading_next;
    logic                              m_valid_reg, m_valid_next;

    odh_pkg::odh_cordic_ctl_t          cordic_ctl;
    logic                              cordic_done;
    logic signed [ANGLE_W-1:0]         cordic_angle;

    logic                              in_accept;
    logic                              commit;
    logic signed [SUM_W-1:0]           sum;
    logic signed [SUM_W-1:0]           sum_biased;
    logic signed [HQ_W-1:0]            head_trunc;
    logic signed [HQ_W-1:0]            head_wrap;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_accept = s_valid && s_ready;

    assign cordic_ctl.start = in_accept;
    assign cordic_ctl.skip  = (s_left_ticks == s_right_ticks);

    odh_cordic #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (cordic_ctl),
        .left_ticks      (s_left_ticks),
        .right_ticks     (s_right_ticks),
        .ticks_per_cm_q4 (tpc_reg),
        .wheel_base_cm   (wb_reg),
        .done            (cordic_done),
        .angle           (cordic_angle)
    );

    // Configuration writes
    always_comb begin
        tpc_next = tpc_reg;
        wb_next  = wb_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                odh_pkg::REG_TICKS_PER_CM: tpc_next = cfg_wdata[odh_pkg::TPC_W-1:0];
                odh_pkg::REG_WHEEL_BASE:   wb_next  = cfg_wdata[odh_pkg::WB_W-1:0];
                default: ;
            endcase
        end
    end

    // New heading: truncate toward zero, then wrap into -180..180
    assign sum        = (SUM_W'(heading_reg) <<< ANGLE_FRAC_BITS) + SUM_W'(cordic_angle);
    assign sum_biased = sum + (sum[SUM_W-1] ? SUM_W'((1 << ANGLE_FRAC_BITS) - 1) : SUM_W'(0));
    assign head_trunc = HQ_W'(sum_biased >>> ANGLE_FRAC_BITS);

    always_comb begin
        if (head_trunc > HQ_W'(odh_pkg::HEAD_LIMIT)) begin
            head_wrap = head_trunc - HQ_W'(odh_pkg::FULL_TURN);
        end else if (head_trunc < -HQ_W'(odh_pkg::HEAD_LIMIT)) begin
            head_wrap = head_trunc + HQ_W'(odh_pkg::FULL_TURN);
        end else begin
            head_wrap = head_trunc;
        end
    end

    // Result slot is free when empty or being drained this cycle
    assign commit = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_accept) state_next = ST_RUN;
            ST_RUN:  if (cordic_done) state_next = ST_FIN;
            ST_FIN:  if (commit) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Heading and result valid
    always_comb begin
        heading_next = heading_reg;
        m_valid_next = m_valid_reg;
        if (commit) begin
            heading_next = head_wrap[odh_pkg::HEAD_W-1:0];
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            tpc_reg     <= odh_pkg::TICKS_PER_CM_RST;
            wb_reg      <= odh_pkg::WHEEL_BASE_RST;
            heading_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            tpc_reg     <= tpc_next;
            wb_reg      <= wb_next;
            heading_reg <= heading_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_heading_deg = heading_reg;

endmodule
